// ===== design/shrp_pkg.sv =====
// ----------------------------------------------------------------------------
// shrp_pkg
// Shared types and constants for the 3x3 sharpen filter.
// ----------------------------------------------------------------------------
package shrp_pkg;

    localparam int MAX_WIDTH_DEF = 2048;
    localparam int PIX_W         = 8;
    localparam int CFG_W         = 12;
    localparam int CFG_IDX_W     = 1;

    localparam logic [CFG_W-1:0]     WIDTH_RST  = 12'd1920;
    localparam logic [CFG_W-1:0]     HEIGHT_RST = 12'd1080;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

    typedef logic [PIX_W-1:0] t_pix;

    typedef struct packed {
        logic flush_col;
        logic flush_row;
        logic has_result;
        logic frame_last;
    } t_scan_info;

endpackage

// ===== design/shrp_ram.sv =====
// ----------------------------------------------------------------------------
// shrp_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module shrp_ram #(
    parameter int DW    = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DW-1:0]            i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DW-1:0]            o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/shrp_scan.sv =====
// ----------------------------------------------------------------------------
// shrp_scan
// Configuration registers, scan position counters and the line store clear
// sweep after reset.
// ----------------------------------------------------------------------------
module shrp_scan #(
    parameter int MAX_WIDTH = shrp_pkg::MAX_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [shrp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [shrp_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_accept,
    output shrp_pkg::t_scan_info           o_info,
    output logic [$clog2(MAX_WIDTH)-1:0]   o_col_addr,
    output logic                           o_busy,
    output logic [$clog2(MAX_WIDTH)-1:0]   o_clr_addr
);
    import shrp_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam logic [CFG_W:0]  MAX_W_EXT = (CFG_W+1)'(MAX_WIDTH);
    localparam logic [AW-1:0]   LAST_ADDR = AW'(MAX_WIDTH - 1);

    logic [CFG_W-1:0] r_width, r_height, r_row, r_col;
    logic [CFG_W-1:0] n_row, n_col;
    logic [CFG_W:0]   w_eff;
    logic             flush_col, flush_row;
    logic             r_busy;
    logic [AW-1:0]    r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WIDTH:  r_width  <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_eff     = ({1'b0, r_width} > MAX_W_EXT) ? MAX_W_EXT : {1'b0, r_width};
    assign flush_col = {1'b0, r_col} >= w_eff;
    assign flush_row = r_row >= r_height;

    always_comb begin
        n_row = r_row;
        n_col = r_col + 1'b1;
        if (flush_col) begin
            n_col = '0;
            n_row = flush_row ? '0 : r_row + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (i_accept) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            if (r_clr_addr == LAST_ADDR) begin
                r_busy <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    assign o_info.flush_col  = flush_col;
    assign o_info.flush_row  = flush_row;
    assign o_info.has_result = (r_row != '0) && (r_col != '0);
    assign o_info.frame_last = flush_col && flush_row;
    assign o_col_addr        = r_col[AW-1:0];
    assign o_busy            = r_busy;
    assign o_clr_addr        = r_clr_addr;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_accept) else $error("word accepted during clear sweep");

    a_col_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && flush_col) |=> (r_col == '0))
        else $error("column did not wrap after flush column");

    a_row_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && flush_col && flush_row) |=> (r_row == '0))
        else $error("row did not wrap at frame end");

endmodule

// ===== design/shrp_kernel.sv =====
// ----------------------------------------------------------------------------
// shrp_kernel
// 3x3 pixel window and sharpen kernel, result held in an output register.
// ----------------------------------------------------------------------------
module shrp_kernel (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_ins,
    input  shrp_pkg::t_pix i_top,
    input  shrp_pkg::t_pix i_mid,
    input  shrp_pkg::t_pix i_bot,
    output shrp_pkg::t_pix o_pixel
);
    import shrp_pkg::*;

    localparam logic signed [PIX_W+3:0] K_CENTER = (PIX_W+4)'(5);

    t_pix r_win [3][3];
    t_pix n_win [3][3];
    t_pix r_pixel;

    logic signed [PIX_W+3:0] acc;
    logic        [PIX_W+3:0] mag;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_win[r][0] = r_win[r][1];
            n_win[r][1] = r_win[r][2];
            n_win[r][2] = r_win[r][2];
        end
        if (i_ins) begin
            n_win[0][2] = i_top;
            n_win[1][2] = i_mid;
            n_win[2][2] = i_bot;
        end
    end

    always_comb begin
        acc = K_CENTER * $signed({4'b0, n_win[1][1]})
            - $signed({4'b0, n_win[0][1]}) - $signed({4'b0, n_win[2][1]})
            - $signed({4'b0, n_win[1][0]}) - $signed({4'b0, n_win[1][2]});
        mag = acc[PIX_W+3] ? -acc : acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[r][c] <= '0;
                end
            end
        end else if (i_en) begin
            r_win <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pixel <= mag[PIX_W-1:0];
        end
    end

    assign o_pixel = r_pixel;

endmodule

// ===== design/sharpen_filter_3x3.sv =====
// ----------------------------------------------------------------------------
// sharpen_filter_3x3
// Streaming 3x3 sharpen filter with a two-line store and a 3x3 window.
// ----------------------------------------------------------------------------
// One scan-step word is taken per clock unless the output stalls or the
// clear sweep runs. A word reads the line store in the cycle it is accepted
// and updates the window, the store and the output register when it
// leaves stage one. Throughput is one word per cycle if nothing stalls,
// set by the line store's read port and write port, each hit at most
// once per word. After reset a sweep zeroes the line store, one column per
// cycle, with s_axis_tready low; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module sharpen_filter_3x3 #(
    parameter int MAX_WIDTH = shrp_pkg::MAX_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [shrp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [shrp_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [7:0] pixel_in
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [7:0]                     m_axis_tdata,   // [7:0] pixel_out
    output logic                           m_axis_tlast    // frame_last
);
    import shrp_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    t_scan_info    info;
    logic [AW-1:0] col_addr, clr_addr;
    logic          busy;
    logic          accept, s1_fire, s1_ready, s2_ready;

    logic          r_s1_valid;
    t_scan_info    r_s1_info;
    t_pix          r_s1_pix;
    logic [AW-1:0] r_s1_addr;

    logic          r_out_valid, r_out_last;

    logic [2*PIX_W-1:0] ram_rdata, ram_wdata;
    logic [AW-1:0]      ram_waddr;
    logic               ram_we;
    t_pix               top, mid, bot;

    assign s2_ready      = !r_out_valid || m_axis_tready;
    assign s1_fire       = r_s1_valid && s2_ready;
    assign s1_ready      = !r_s1_valid || s2_ready;
    assign s_axis_tready = s1_ready && !busy;
    assign accept        = s_axis_tvalid && s_axis_tready;

    shrp_scan #(.MAX_WIDTH(MAX_WIDTH)) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .o_info     (info),
        .o_col_addr (col_addr),
        .o_busy     (busy),
        .o_clr_addr (clr_addr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_info <= info;
            r_s1_pix  <= s_axis_tdata;
            r_s1_addr <= col_addr;
        end
    end

    // line store word: [15:8] older line, [7:0] newest line
    assign top = ram_rdata[2*PIX_W-1:PIX_W];
    assign mid = ram_rdata[PIX_W-1:0];
    assign bot = r_s1_info.flush_row ? '0 : r_s1_pix;

    always_comb begin
        if (busy) begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr;
            ram_wdata = '0;
        end else begin
            ram_we    = s1_fire && !r_s1_info.flush_col;
            ram_waddr = r_s1_addr;
            ram_wdata = {mid, r_s1_info.flush_row ? mid : r_s1_pix};
        end
    end

    shrp_ram #(.DW(2*PIX_W), .DEPTH(MAX_WIDTH)) u_line (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (col_addr),
        .o_rdata (ram_rdata)
    );

    shrp_kernel u_kernel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (s1_fire),
        .i_ins   (!r_s1_info.flush_col),
        .i_top   (top),
        .i_mid   (mid),
        .i_bot   (bot),
        .o_pixel (m_axis_tdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire) begin
            r_out_valid <= r_s1_info.has_result;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_last <= r_s1_info.frame_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;

    a_s1_empty_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !r_s1_valid) else $error("pipeline occupied during clear sweep");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(s1_fire))
        else $error("output word without a stage one advance");

    a_no_stage_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s2_ready) |=> (r_s1_valid && $stable(r_s1_addr)))
        else $error("stalled stage one word lost");

    a_flush_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!busy && r_s1_info.flush_col && r_s1_valid) |-> !ram_we)
        else $error("line store written on flush column");

endmodule

// ===== sim/tb_sharpen_filter_3x3.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sharpen_filter_3x3
// Self-checking bench for the streaming 3x3 sharpen filter.
// ----------------------------------------------------------------------------
// A directed table runs first: reset defaults, a tiny frame with hand-worked
// results (including the wrap of 5*255 to its low byte), the flush row and
// the flush column. Fixed phases then cover the register extremes (zero
// sizes, full width, width past the line store, tallest frame). Random
// phases with random sizes, mid-frame size changes and random handshake
// pressure follow. Every word out is checked against a given table value or
// an in-bench scan model of line store, window and row and column counters.
// ----------------------------------------------------------------------------
module tb_sharpen_filter_3x3;
    import shrp_pkg::*;

    localparam int CLK_HALF  = 6;
    localparam int RST_CYC   = 9;
    localparam int SETTLE    = 8;
    localparam int CYC_LIMIT = 1000000;
    localparam int RAND_GOAL = 1660;
    localparam int LINE_LEN  = MAX_WIDTH_DEF;

    typedef enum logic [1:0] {ROW_PIX, ROW_SET_WIDTH, ROW_SET_HEIGHT} t_row_kind;
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_GIVEN} t_chk;
    typedef enum logic [1:0] {IDLE_OFF, IDLE_SRC, IDLE_SINK, IDLE_BOTH} t_idle;

    typedef struct packed {
        t_pix pix;
        logic last;
    } t_sharp_word;

    typedef struct packed {
        t_row_kind         kind;
        logic [CFG_W-1:0]  val;
        t_chk              chk;
        t_pix              ex_pix;
        logic              ex_last;
    } t_dir_row;

    localparam int DIR_N = 24;
    localparam t_dir_row DIR_TBL [DIR_N] = '{
        '{ROW_PIX,        12'd0,   CHK_NONE,  8'd0,   1'b0},
        '{ROW_PIX,        12'd0,   CHK_NONE,  8'd0,   1'b0},
        '{ROW_PIX,        12'd0,   CHK_NONE,  8'd0,   1'b0},
        '{ROW_SET_WIDTH,  12'd3,   CHK_MODEL, 8'd0,   1'b0},
        '{ROW_SET_HEIGHT, 12'd3,   CHK_MODEL, 8'd0,   1'b0},
        '{ROW_PIX,        12'd0,   CHK_NONE,  8'd0,   1'b0},
        '{ROW_PIX,        12'd0,   CHK_NONE,  8'd0,   1'b0},
        '{ROW_PIX,        12'd255, CHK_GIVEN, 8'd0,   1'b0},
        '{ROW_PIX,        12'd0,   CHK_GIVEN, 8'd255, 1'b0},
        '{ROW_PIX,        12'd0,   CHK_MODEL, 8'd0,   1'b0},
        '{ROW_PIX,        12'd0,   CHK_NONE,  8'd0,   1'b0},
        '{ROW_PIX,        12'd0,   CHK_MODEL, 8'd0,   1'b0},
        '{ROW_PIX,        12'd0,   CHK_GIVEN, 8'd251, 1'b0},
        '{ROW_PIX,        12'd0,   CHK_MODEL, 8'd0,   1'b0},
        '{ROW_PIX,        12'd255, CHK_MODEL, 8'd0,   1'b0},
        '{ROW_PIX,        12'd255, CHK_MODEL, 8'd0,   1'b0},
        '{ROW_PIX,        12'd255, CHK_MODEL, 8'd0,   1'b0},
        '{ROW_PIX,        12'd255, CHK_MODEL, 8'd0,   1'b0},
        '{ROW_PIX,        12'd255, CHK_NONE,  8'd0,   1'b0},
        '{ROW_PIX,        12'd128, CHK_NONE,  8'd0,   1'b0},
        '{ROW_PIX,        12'd1,   CHK_NONE,  8'd0,   1'b0},
        '{ROW_PIX,        12'd254, CHK_MODEL, 8'd0,   1'b0},
        '{ROW_PIX,        12'd85,  CHK_MODEL, 8'd0,   1'b0},
        '{ROW_PIX,        12'd170, CHK_MODEL, 8'd0,   1'b0}
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = CFG_WIDTH;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    t_pix                 in_data = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_pix                 out_data;
    logic                 out_last;

    sharpen_filter_3x3 dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (in_valid),
        .s_axis_tready (in_ready),
        .s_axis_tdata  (in_data),
        .m_axis_tvalid (out_valid),
        .m_axis_tready (out_ready),
        .m_axis_tdata  (out_data),
        .m_axis_tlast  (out_last)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // scan model state
    logic [CFG_W-1:0] span_cfg = WIDTH_RST;
    logic [CFG_W-1:0] rows_cfg = HEIGHT_RST;
    t_pix             line_new [LINE_LEN] = '{default: '0};
    t_pix             line_old [LINE_LEN] = '{default: '0};
    t_pix             win [3][3] = '{default: '0};
    logic [CFG_W-1:0] row_cnt = '0;
    logic [CFG_W-1:0] col_cnt = '0;

    t_sharp_word sharpened_q [$];
    int          err_cnt = 0;
    int          cyc_cnt = 0;
    int          src_gap_pct = 0;
    int          sink_stall_pct = 0;

    function automatic void sharpen_step(input t_pix p, output bit got,
                                         output t_sharp_word w);
        int unsigned span;
        bit          fcol;
        bit          frow;
        t_pix        top;
        t_pix        mid;
        t_pix        bot;
        int          acc;
        int          r;
        span = (span_cfg > LINE_LEN) ? LINE_LEN : span_cfg;
        fcol = col_cnt >= span;
        frow = row_cnt >= rows_cfg;
        top  = '0;
        mid  = '0;
        bot  = '0;
        if (!fcol) begin
            top = line_old[col_cnt];
            mid = line_new[col_cnt];
            line_old[col_cnt] = mid;
            if (!frow) begin
                bot = p;
                line_new[col_cnt] = p;
            end
        end
        for (r = 0; r < 3; r++) begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        if (!fcol) begin
            win[0][2] = top;
            win[1][2] = mid;
            win[2][2] = bot;
        end
        got = (row_cnt != 0) && (col_cnt != 0);
        acc = 5 * int'(win[1][1]) - int'(win[0][1]) - int'(win[1][0])
              - int'(win[1][2]) - int'(win[2][1]);
        if (acc < 0) acc = -acc;
        w.pix  = acc[7:0];
        w.last = frow && fcol;
        if (fcol) begin
            col_cnt = '0;
            row_cnt = frow ? '0 : row_cnt + 1'b1;
        end else begin
            col_cnt = col_cnt + 1'b1;
        end
    endfunction

    function automatic t_pix rnd_pixel();
        case ($urandom_range(7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return t_pix'($urandom_range(255));
        endcase
    endfunction

    function automatic void set_idle(input t_idle mode);
        src_gap_pct    = (mode == IDLE_SRC) ? 61 : (mode == IDLE_BOTH) ? 26 : 0;
        sink_stall_pct = (mode == IDLE_SINK) ? 61 : (mode == IDLE_BOTH) ? 26 : 0;
    endfunction

    task automatic push_word(input t_pix p, input t_chk chk, input t_sharp_word given);
        bit          got;
        t_sharp_word w;
        while ($urandom_range(99) < src_gap_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= p;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        sharpen_step(p, got, w);
        if (chk == CHK_GIVEN) sharpened_q.push_back(given);
        else if (chk == CHK_MODEL && got) sharpened_q.push_back(w);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (sharpened_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        drain_results();
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_WIDTH) span_cfg = val;
        else rows_cfg = val;
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                             input int n, input t_idle mode);
        int k;
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        set_idle(mode);
        for (k = 0; k < n; k++) push_word(rnd_pixel(), CHK_MODEL, '0);
    endtask

    always @(posedge i_clk) begin
        out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        t_sharp_word exp_w;
        if (i_rst_n === 1'b1 && out_valid === 1'b1 && out_ready) begin
            if (sharpened_q.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected word, expected none, actual pixel %0d last %0b",
                         $time, out_data, out_last);
            end else begin
                exp_w = sharpened_q.pop_front();
                if (out_data !== exp_w.pix || out_last !== exp_w.last) begin
                    err_cnt++;
                    $display("%0t: mismatch, expected pixel %0d last %0b, actual pixel %0d last %0b",
                             $time, exp_w.pix, exp_w.last, out_data, out_last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cyc_cnt++;
        if (cyc_cnt > CYC_LIMIT) begin
            $display("FAIL sharpen_filter_3x3");
            $finish;
        end
    end

    initial begin
        int          i;
        int          ph;
        int          n;
        int          rand_cnt;
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;
        t_sharp_word given;
        repeat (RST_CYC) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_idle(IDLE_OFF);
        for (i = 0; i < DIR_N; i++) begin
            given.pix  = DIR_TBL[i].ex_pix;
            given.last = DIR_TBL[i].ex_last;
            case (DIR_TBL[i].kind)
                ROW_SET_WIDTH:  write_reg(CFG_WIDTH, DIR_TBL[i].val);
                ROW_SET_HEIGHT: write_reg(CFG_HEIGHT, DIR_TBL[i].val);
                default:        push_word(DIR_TBL[i].val[7:0], DIR_TBL[i].chk, given);
            endcase
        end

        run_phase(12'd0,    12'd5,    20, IDLE_SRC);
        run_phase(12'd7,    12'd0,    24, IDLE_SINK);
        run_phase(12'd4095, 12'd1,    60, IDLE_OFF);
        run_phase(12'd2048, 12'd1,    60, IDLE_BOTH);
        run_phase(12'd3,    12'd4095, 60, IDLE_SRC);
        run_phase(12'd3,    12'd3,    40, IDLE_OFF);

        rand_cnt = 0;
        ph = 0;
        while (rand_cnt < RAND_GOAL) begin
            w = ($urandom_range(9) == 0) ? CFG_W'($urandom_range(4095))
                                         : CFG_W'($urandom_range(1, 12));
            h = ($urandom_range(9) == 0) ? CFG_W'($urandom_range(4095))
                                         : CFG_W'($urandom_range(1, 8));
            n = $urandom_range(40, 160);
            run_phase(w, h, n, t_idle'(ph % 4));
            rand_cnt += n;
            ph++;
        end

        drain_results();
        if (err_cnt == 0 && sharpened_q.size() == 0) begin
            $display("PASS sharpen_filter_3x3");
        end else begin
            $display("FAIL sharpen_filter_3x3");
        end
        $finish;
    end

endmodule
